@@ hdl/stb_pkg.sv @@
// Shared types and codes for the software timer bank.
`timescale 1ns / 1ps

package stb_pkg;

   // Command codes carried in the kind field of a request beat.
   typedef enum logic [2:0] {
      KIND_TICK       = 3'd0,
      KIND_LOAD_START = 3'd1,
      KIND_LOAD       = 3'd2,
      KIND_CLEAR_EXP  = 3'd3,
      KIND_START      = 3'd4,
      KIND_STOP       = 3'd5,
      KIND_QUERY      = 3'd6,
      KIND_READ_TIME  = 3'd7
   } kind_type;

   // Response status codes.
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_BAD_INDEX = 1'b1;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SWEEP  = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   localparam int TICK_BITS  = 16;
   localparam int INDEX_BITS = 8;
   localparam int VALUE_BITS = 16;

endpackage

@@ hdl/software_timer_bank_top.sv @@
// Top level of the software timer bank: engine plus remaining-count memory.
// A command beat is registered into the response register in the cycle after acceptance.
// A tick beat sweeps the count memory one timer per cycle, then waits in the finish state
// until the response slot is free; no further beat is accepted until it has returned to idle.
// Commands sustain one per cycle while responses are taken and no tick sweep is in progress.
// Reset clears the active and expired masks and the tick counter; counts hold until loaded.
`timescale 1ns / 1ps

module software_timer_bank_top #(
   parameter int TIMER_COUNT = 16,
   parameter int COUNT_BITS  = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [2:0]                      req_kind,
   input  logic [stb_pkg::INDEX_BITS-1:0]  req_timer_index,
   input  logic [stb_pkg::VALUE_BITS-1:0]  req_count_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_status,
   output logic                            rsp_active_flag,
   output logic                            rsp_expired_flag,
   output logic [stb_pkg::TICK_BITS-1:0]   rsp_elapsed_ticks
);

   localparam int IDX_BITS = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

   logic                  mem_wr_en;
   logic [IDX_BITS-1:0]   mem_wr_addr;
   logic [COUNT_BITS-1:0] mem_wr_data;
   logic                  mem_rd_en;
   logic [IDX_BITS-1:0]   mem_rd_addr;
   logic [COUNT_BITS-1:0] mem_rd_data;

   stb_engine #(
      .TIMER_COUNT (TIMER_COUNT),
      .COUNT_BITS  (COUNT_BITS),
      .IDX_BITS    (IDX_BITS)
   ) u_engine (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_timer_index   (req_timer_index),
      .req_count_value   (req_count_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_active_flag   (rsp_active_flag),
      .rsp_expired_flag  (rsp_expired_flag),
      .rsp_elapsed_ticks (rsp_elapsed_ticks),
      .mem_wr_en         (mem_wr_en),
      .mem_wr_addr       (mem_wr_addr),
      .mem_wr_data       (mem_wr_data),
      .mem_rd_en         (mem_rd_en),
      .mem_rd_addr       (mem_rd_addr),
      .mem_rd_data       (mem_rd_data)
   );

   stb_count_ram #(
      .DEPTH     (TIMER_COUNT),
      .ADDR_BITS (IDX_BITS),
      .DATA_BITS (COUNT_BITS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

@@ hdl/stb_count_ram.sv @@
// Remaining-count memory: one write port, one registered read port.
`timescale 1ns / 1ps

module stb_count_ram #(
   parameter int DEPTH     = 16,
   parameter int ADDR_BITS = 4,
   parameter int DATA_BITS = 16
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/stb_engine.sv @@
// Command decoder, tick sweep sequencer, flag masks and response register.
`timescale 1ns / 1ps

module stb_engine #(
   parameter int TIMER_COUNT = 16,
   parameter int COUNT_BITS  = 16,
   parameter int IDX_BITS    = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [2:0]                      req_kind,
   input  logic [stb_pkg::INDEX_BITS-1:0]  req_timer_index,
   input  logic [stb_pkg::VALUE_BITS-1:0]  req_count_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_status,
   output logic                            rsp_active_flag,
   output logic                            rsp_expired_flag,
   output logic [stb_pkg::TICK_BITS-1:0]   rsp_elapsed_ticks,
   output logic                            mem_wr_en,
   output logic [IDX_BITS-1:0]             mem_wr_addr,
   output logic [COUNT_BITS-1:0]           mem_wr_data,
   output logic                            mem_rd_en,
   output logic [IDX_BITS-1:0]             mem_rd_addr,
   input  logic [COUNT_BITS-1:0]           mem_rd_data
);

   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(TIMER_COUNT - 1);

   stb_pkg::state_type state_ff, state_in;
   logic [TIMER_COUNT-1:0] active_mask_ff, active_mask_in;
   logic [TIMER_COUNT-1:0] expired_mask_ff, expired_mask_in;
   logic [stb_pkg::TICK_BITS-1:0] tick_count_ff, tick_count_in;
   logic [IDX_BITS-1:0] sweep_idx_ff, sweep_idx_in;
   logic s1_valid_ff, s1_valid_in;
   logic [IDX_BITS-1:0] s1_idx_ff, s1_idx_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_status_ff, rsp_status_in;
   logic rsp_active_ff, rsp_active_in;
   logic rsp_expired_ff, rsp_expired_in;
   logic [stb_pkg::TICK_BITS-1:0] rsp_ticks_ff, rsp_ticks_in;

   stb_pkg::kind_type kind;
   logic slot_free;
   logic accept;
   logic out_of_range;
   logic [IDX_BITS-1:0] cmd_idx;
   logic [COUNT_BITS-1:0] dec_count;

   assign kind         = stb_pkg::kind_type'(req_kind);
   assign slot_free    = !rsp_valid_ff || !rsp_stall;
   assign out_of_range = req_timer_index >= stb_pkg::INDEX_BITS'(TIMER_COUNT);
   assign cmd_idx      = req_timer_index[IDX_BITS-1:0];
   assign dec_count    = mem_rd_data - COUNT_BITS'(1);

   // A tick does not need the response slot until its sweep is done.
   assign req_stall = !((state_ff == stb_pkg::ST_IDLE) &&
                        ((kind == stb_pkg::KIND_TICK) || slot_free));
   assign accept    = req_valid && !req_stall;

   assign mem_rd_en   = (state_ff == stb_pkg::ST_SWEEP);
   assign mem_rd_addr = sweep_idx_ff;

   always_comb begin
      state_in        = state_ff;
      active_mask_in  = active_mask_ff;
      expired_mask_in = expired_mask_ff;
      tick_count_in   = tick_count_ff;
      sweep_idx_in    = sweep_idx_ff;
      s1_valid_in     = 1'b0;
      s1_idx_in       = sweep_idx_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_status_in   = rsp_status_ff;
      rsp_active_in   = rsp_active_ff;
      rsp_expired_in  = rsp_expired_ff;
      rsp_ticks_in    = rsp_ticks_ff;
      mem_wr_en       = 1'b0;
      mem_wr_addr     = s1_idx_ff;
      mem_wr_data     = dec_count;

      // Second sweep stage: the count read last cycle is decremented and written back; at zero the timer expires.
      if (s1_valid_ff) begin
         mem_wr_en = 1'b1;
         if (dec_count == '0) begin
            active_mask_in[s1_idx_ff]  = 1'b0;
            expired_mask_in[s1_idx_ff] = 1'b1;
         end
      end

      unique case (state_ff)
         stb_pkg::ST_IDLE: begin
            if (accept) begin
               if (kind == stb_pkg::KIND_TICK) begin
                  tick_count_in = tick_count_ff + stb_pkg::TICK_BITS'(1);
                  sweep_idx_in  = '0;
                  state_in      = stb_pkg::ST_SWEEP;
               end else begin
                  rsp_valid_in   = 1'b1;
                  rsp_status_in  = stb_pkg::STATUS_OK;
                  rsp_active_in  = 1'b0;
                  rsp_expired_in = 1'b0;
                  rsp_ticks_in   = tick_count_ff;
                  if (kind != stb_pkg::KIND_READ_TIME) begin
                     if (out_of_range) begin
                        rsp_status_in = stb_pkg::STATUS_BAD_INDEX;
                     end else begin
                        case (kind)
                           stb_pkg::KIND_LOAD_START: begin
                              mem_wr_en                = 1'b1;
                              expired_mask_in[cmd_idx] = 1'b0;
                              active_mask_in[cmd_idx]  = 1'b1;
                           end
                           stb_pkg::KIND_LOAD: begin
                              mem_wr_en = 1'b1;
                           end
                           stb_pkg::KIND_CLEAR_EXP: begin
                              expired_mask_in[cmd_idx] = 1'b0;
                           end
                           stb_pkg::KIND_START: begin
                              active_mask_in[cmd_idx] = 1'b1;
                           end
                           stb_pkg::KIND_STOP: begin
                              active_mask_in[cmd_idx] = 1'b0;
                           end
                           default: begin
                           end
                        endcase
                        mem_wr_addr    = cmd_idx;
                        mem_wr_data    = COUNT_BITS'(req_count_value);
                        rsp_active_in  = active_mask_in[cmd_idx];
                        rsp_expired_in = expired_mask_in[cmd_idx];
                     end
                  end
               end
            end
         end
         stb_pkg::ST_SWEEP: begin
            // Only active timers get a read-modify-write slot.
            s1_valid_in  = active_mask_ff[sweep_idx_ff];
            s1_idx_in    = sweep_idx_ff;
            sweep_idx_in = sweep_idx_ff + IDX_BITS'(1);
            if (sweep_idx_ff == LAST_IDX) begin
               state_in = stb_pkg::ST_FINISH;
            end
         end
         stb_pkg::ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = stb_pkg::STATUS_OK;
               rsp_active_in  = 1'b0;
               rsp_expired_in = 1'b0;
               rsp_ticks_in   = tick_count_ff;
               state_in       = stb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = stb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= stb_pkg::ST_IDLE;
         active_mask_ff  <= '0;
         expired_mask_ff <= '0;
         tick_count_ff   <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         active_mask_ff  <= active_mask_in;
         expired_mask_ff <= expired_mask_in;
         tick_count_ff   <= tick_count_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sweep_idx_ff   <= sweep_idx_in;
      s1_idx_ff      <= s1_idx_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_active_ff  <= rsp_active_in;
      rsp_expired_ff <= rsp_expired_in;
      rsp_ticks_ff   <= rsp_ticks_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_active_flag   = rsp_active_ff;
   assign rsp_expired_flag  = rsp_expired_ff;
   assign rsp_elapsed_ticks = rsp_ticks_ff;

`ifndef SYNTHESIS
   a_s1_only_in_sweep: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (state_ff == stb_pkg::ST_SWEEP || state_ff == stb_pkg::ST_FINISH))
      else $error("write-back stage busy outside a tick sweep");

   a_s1_timer_active: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> active_mask_ff[s1_idx_ff])
      else $error("write-back stage holds a timer that is not active");

   a_tick_advances: assert property (@(posedge clock) disable iff (reset)
      (accept && kind == stb_pkg::KIND_TICK) |=>
         (tick_count_ff == $past(tick_count_ff) + stb_pkg::TICK_BITS'(1)))
      else $error("tick beat did not advance the tick counter");

   a_error_no_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == stb_pkg::STATUS_BAD_INDEX) |->
         (!rsp_active_ff && !rsp_expired_ff))
      else $error("error response carries timer flags");
`endif

endmodule
